// ===== hdl/cmll_pkg.sv =====
package cmll_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
   localparam logic [1:0] REG_RANGE_MAX   = 2'd1;
   localparam logic [1:0] REG_SCALE       = 2'd2;
   localparam logic [1:0] REG_ENTRY_COUNT = 2'd3;

   // input word kinds
   localparam logic MODE_MAP   = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // register reset values
   localparam logic signed [31:0] RANGE_MIN_RESET   = 32'sd0;
   localparam logic signed [31:0] RANGE_MAX_RESET   = 32'sd255;
   localparam logic [23:0]        SCALE_RESET       = 24'd65536;
   localparam logic [8:0]         ENTRY_COUNT_RESET = 9'd256;

   // one palette entry, red in the low byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   // weighted blend of two channel values with rounding, frac is 0.16
   function automatic logic [7:0] blend_chan(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [15:0] frac);
      logic [16:0] w_lo;
      logic [23:0] acc;
      w_lo = 17'h10000 - {1'b0, frac};
      acc  = 24'(lo) * 24'(w_lo) + 24'(hi) * 24'(frac) + 24'h008000;
      return acc[23:16];
   endfunction

   function automatic rgba_type blend_rgba(input rgba_type lo, input rgba_type hi,
                                           input logic [15:0] frac);
      rgba_type r;
      r.red   = blend_chan(lo.red,   hi.red,   frac);
      r.green = blend_chan(lo.green, hi.green, frac);
      r.blue  = blend_chan(lo.blue,  hi.blue,  frac);
      r.alpha = blend_chan(lo.alpha, hi.alpha, frac);
      return r;
   endfunction

endpackage

// ===== hdl/color_map_lerp_lookup.sv =====
// Color map with linear interpolation between palette entries.
// req channel: tuser is the kind of word (0 map a scalar, 1 write a palette
// entry), tdata carries the scalar and the entry index and color. A write
// word stores one entry and gives no response. A map word
// gives one rsp word holding the RGBA color.
// csr channel: csr_index selects range_min, range_max, scale or entry_count,
// csr_data carries the value; always ready. The user must write it only while
// the block is idle; the block itself does not enforce it. A map word passes
// subtract and compare at acceptance, then the 32x24 scale multiply, the
// palette read, and the blend into the output register that drives rsp_tvalid.
// One word is worked on at a time, so a new req word is taken only once the
// last map word has left the blend stage.
// The palette is held in two copies of a synchronous RAM so that both
// neighbor entries are read in the same cycle.
// The response sits in an output register: a new req word is accepted while
// it waits, and a stalled rsp_tready holds the next result in the blend
// stage until the register frees up.
// Reset clears the control state and the registers to their defaults; the
// palette contents are undefined until written.
module color_map_lerp_lookup #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: scalar[31:0], entry_index[39:32], entry_red[47:40],
   // entry_green[55:48], entry_blue[63:56], entry_alpha[71:64]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // req_tuser: mode[0]
   input  logic [0:0]  req_tuser,
   // rsp_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import cmll_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CLW   = $clog2(MAX_ENTRIES + 1);
   localparam int NW    = (CLW > 9) ? CLW : 9;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADDR = 2'd2;
   localparam logic [1:0] ST_READ = 2'd3;

   logic [1:0] state_ff, state_in;

   logic signed [31:0] range_min_ff, range_max_ff;
   logic [23:0]        scale_ff;
   logic [8:0]         count_ff;

   logic [31:0] diff_ff;
   logic        below_ff, above_ff;
   logic [55:0] pos_ff;
   logic [15:0] frac_ff;
   logic        direct_ff;

   rgba_type pal_a_mem [MAX_ENTRIES];
   rgba_type pal_b_mem [MAX_ENTRIES];
   rgba_type rd_a_ff, rd_b_ff;

   logic     out_valid_ff;
   rgba_type out_data_ff;

   logic signed [31:0] req_scalar;
   logic [7:0]         req_idx;
   rgba_type           req_color;
   logic               req_fire, wr_en, rd_en, out_load;
   logic [NW-1:0]      n_clamp;
   logic [IDX_W-1:0]   last_idx, base_idx, addr_a, addr_b;
   logic [39:0]        base;
   logic               direct_now;
   rgba_type           blend_out;

   // unpack request word
   assign req_scalar = $signed(req_tdata[31:0]);
   assign req_idx    = req_tdata[39:32];
   assign req_color  = rgba_type'(req_tdata[71:40]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = req_fire && (req_tuser[0] == MODE_WRITE)
                       && ({24'b0, req_idx} < 32'(MAX_ENTRIES));
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= RANGE_MIN_RESET;
         range_max_ff <= RANGE_MAX_RESET;
         scale_ff     <= SCALE_RESET;
         count_ff     <= ENTRY_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RANGE_MIN:   range_min_ff <= $signed(csr_data);
            REG_RANGE_MAX:   range_max_ff <= $signed(csr_data);
            REG_SCALE:       scale_ff     <= csr_data[23:0];
            REG_ENTRY_COUNT: count_ff     <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // last entry in use, count clamped to 1..MAX_ENTRIES
   always_comb begin
      n_clamp = NW'(count_ff);
      if (n_clamp == '0) begin
         n_clamp = NW'(1);
      end else if (n_clamp > NW'(MAX_ENTRIES)) begin
         n_clamp = NW'(MAX_ENTRIES);
      end
      last_idx = IDX_W'(n_clamp - NW'(1));
   end

   // position split and read addresses
   assign base       = pos_ff[55:16];
   assign base_idx   = base[IDX_W-1:0];
   assign direct_now = below_ff || above_ff || (base >= 40'(last_idx));
   always_comb begin
      if (below_ff) begin
         addr_a = '0;
      end else if (direct_now) begin
         addr_a = last_idx;
      end else begin
         addr_a = base_idx;
      end
      addr_b = base_idx + IDX_W'(1);
   end
   assign rd_en = (state_ff == ST_ADDR);

   // palette copies, one write port and one registered read port each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_a_mem[IDX_W'(req_idx)] <= req_color;
         pal_b_mem[IDX_W'(req_idx)] <= req_color;
      end
      if (rd_en) begin
         rd_a_ff <= pal_a_mem[addr_a];
         rd_b_ff <= pal_b_mem[addr_b];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         diff_ff  <= 32'(req_scalar - range_min_ff);
         below_ff <= (req_scalar <= range_min_ff);
         above_ff <= (req_scalar >= range_max_ff);
      end
      if (state_ff == ST_MUL) begin
         pos_ff <= 56'(diff_ff) * 56'(scale_ff);
      end
      if (state_ff == ST_ADDR) begin
         frac_ff   <= pos_ff[15:0];
         direct_ff <= direct_now;
      end
   end

   // blend or pass the entry through
   assign blend_out = direct_ff ? rd_a_ff : blend_rgba(rd_a_ff, rd_b_ff, frac_ff);
   assign out_load  = (state_ff == ST_READ) && (!out_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire && (req_tuser[0] == MODE_MAP)) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_READ;
         ST_READ: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= blend_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== tb/sv/tb_color_map_lerp_lookup.sv =====
`timescale 1ns / 1ps

import cmll_pkg::*;

// holds the palette and registers as the block should see them and predicts
// the color for every lookup word
class rgba_predictor;
   rgba_type    palette [256];
   logic [31:0] range_lo;
   logic [31:0] range_hi;
   logic [23:0] scale;
   logic [8:0]  count;
   rgba_type    expected_colors [$];
   int          errors;
   int          lookups;
   int          writes;

   function new();
      range_lo = RANGE_MIN_RESET;
      range_hi = RANGE_MAX_RESET;
      scale    = SCALE_RESET;
      count    = ENTRY_COUNT_RESET;
      errors   = 0;
      lookups  = 0;
      writes   = 0;
   endfunction

   function void set_reg(input logic [1:0] index, input logic [31:0] value);
      case (index)
         REG_RANGE_MIN:   range_lo = value;
         REG_RANGE_MAX:   range_hi = value;
         REG_SCALE:       scale = value[23:0];
         REG_ENTRY_COUNT: count = value[8:0];
         default: ;
      endcase
   endfunction

   // rounded weighted mix of two channel values, frac is 0.16
   function logic [7:0] mix(input logic [7:0] lo, input logic [7:0] hi,
                            input logic [15:0] frac);
      longint acc;
      acc = longint'(lo) * (65536 - longint'(frac)) + longint'(hi) * longint'(frac) + 32768;
      return 8'(acc >> 16);
   endfunction

   function rgba_type predict(input logic [31:0] scalar);
      logic [31:0] s_ord;
      logic [31:0] lo_ord;
      logic [31:0] hi_ord;
      logic [55:0] pos;
      logic [39:0] base;
      logic [15:0] frac;
      int          n;
      int          last;
      rgba_type    lo;
      rgba_type    hi;
      rgba_type    r;
      n = count;
      if (n < 1) n = 1;
      if (n > 256) n = 256;
      last = n - 1;
      // flip the sign bit so unsigned compares follow signed order
      s_ord  = scalar ^ 32'h8000_0000;
      lo_ord = range_lo ^ 32'h8000_0000;
      hi_ord = range_hi ^ 32'h8000_0000;
      if (s_ord <= lo_ord) return palette[0];
      if (s_ord >= hi_ord) return palette[last];
      pos  = 56'(s_ord - lo_ord) * 56'(scale);
      base = pos[55:16];
      frac = pos[15:0];
      if (base >= 40'(last)) return palette[last];
      lo = palette[base];
      hi = palette[base + 1];
      r.red   = mix(lo.red,   hi.red,   frac);
      r.green = mix(lo.green, hi.green, frac);
      r.blue  = mix(lo.blue,  hi.blue,  frac);
      r.alpha = mix(lo.alpha, hi.alpha, frac);
      return r;
   endfunction

   // called at the edge where a request word is taken
   function void note_request(input logic mode, input logic [71:0] data);
      if (mode == MODE_WRITE) begin
         palette[data[39:32]] = rgba_type'(data[71:40]);
         writes++;
      end else begin
         expected_colors.push_back(predict(data[31:0]));
         lookups++;
      end
   endfunction

   function void check_response(input logic [31:0] data);
      rgba_type got;
      rgba_type want;
      got = rgba_type'(data);
      if (expected_colors.size() == 0) begin
         $error("response word 0x%08h with no lookup outstanding", data);
         errors++;
         return;
      end
      want = expected_colors.pop_front();
      if (got.red !== want.red) begin
         $error("red: expected 0x%02h, got 0x%02h", want.red, got.red);
         errors++;
      end
      if (got.green !== want.green) begin
         $error("green: expected 0x%02h, got 0x%02h", want.green, got.green);
         errors++;
      end
      if (got.blue !== want.blue) begin
         $error("blue: expected 0x%02h, got 0x%02h", want.blue, got.blue);
         errors++;
      end
      if (got.alpha !== want.alpha) begin
         $error("alpha: expected 0x%02h, got 0x%02h", want.alpha, got.alpha);
         errors++;
      end
   endfunction

   function int pending();
      return expected_colors.size();
   endfunction
endclass

module tb_color_map_lerp_lookup;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 113;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: scalar, entry_index, entry_red, entry_green, entry_blue, entry_alpha
   logic [71:0] req_tdata = '0;
   // req_tuser: mode
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: red, green, blue, alpha
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   rgba_predictor rgba_model = new();
   int  cycles = 0;
   int  settings = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   color_map_lerp_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random stalls, check each word taken
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rgba_model.check_response(rsp_tdata);
         @(negedge clock);
      end
   end

   // one request word: random gap, then hold until taken; ends on a falling edge
   task automatic send_word(input logic mode, input logic [71:0] data);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rgba_model.note_request(mode, data);
      @(negedge clock);
   endtask

   // unused fields carry random noise
   task automatic send_map(input logic [31:0] scalar);
      logic [39:0] noise;
      noise = {8'($urandom), 32'($urandom)};
      send_word(MODE_MAP, {noise, scalar});
   endtask

   task automatic send_entry(input logic [7:0] index, input logic [31:0] color);
      send_word(MODE_WRITE, {color, index, 32'($urandom)});
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rgba_model.set_reg(index, value);
      @(negedge clock);
   endtask

   // drain every lookup, let trailing palette writes settle, then reprogram
   task automatic program_regs(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [23:0] scl, input logic [8:0] cnt);
      req_tvalid <= 1'b0;
      while (rgba_model.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      write_reg(REG_RANGE_MIN, lo);
      write_reg(REG_RANGE_MAX, hi);
      write_reg(REG_SCALE, {8'd0, scl});
      write_reg(REG_ENTRY_COUNT, {23'd0, cnt});
      csr_valid <= 1'b0;
      settings++;
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
   endtask

   // scale the way software would set it: (entries - 1) / (max - min) in Q8.16
   function automatic logic [23:0] fit_scale(input logic signed [31:0] lo,
                                              input logic signed [31:0] hi,
                                              input int cnt);
      longint span;
      longint s;
      int     n;
      if (hi <= lo) return 24'd65536;
      n = (cnt < 1) ? 1 : ((cnt > 256) ? 256 : cnt);
      span = longint'(hi) - longint'(lo);
      s = (longint'(n - 1) << 16) / span;
      if (s < 1) s = 1;
      if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
      return 24'(s);
   endfunction

   // mostly lookups spread across the range, some at its edges, some entry writes
   task automatic run_phase(input logic signed [31:0] lo, input logic signed [31:0] hi,
                            input logic [23:0] scl, input logic [8:0] cnt);
      int          pick;
      longint      span;
      logic [31:0] r32;
      program_regs(lo, hi, scl, cnt);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         r32 = $urandom;
         if (k == PHASE_ITEMS / 2) begin
            req_calm = ~req_calm;
            rsp_calm = ($urandom_range(0, 2) == 0);
         end
         if (pick < 15) begin
            send_entry(8'($urandom), r32);
         end else if (pick < 65 && hi > lo) begin
            span = longint'(hi) - longint'(lo) + 1;
            send_map(32'(longint'(lo) + longint'({32'd0, r32}) % span));
         end else if (pick < 75) begin
            send_map(lo + 32'($urandom_range(0, 2)) - 32'd1);
         end else if (pick < 85) begin
            send_map(hi + 32'($urandom_range(0, 2)) - 32'd1);
         end else begin
            send_map(r32);
         end
      end
   endtask

   initial begin
      logic signed [31:0] rlo;
      logic signed [31:0] rhi;
      int                 rcnt;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // load every palette entry before any lookup can read it
      for (int i = 0; i < 256; i++) send_entry(8'(i), $urandom);

      // default registers: scalar k lands exactly on entry k
      send_map(32'sh8000_0000);
      send_map(-1);
      send_map(0);
      send_map(1);
      send_map(128);
      send_map(254);
      send_map(255);
      send_map(256);
      send_map(32'sh7FFF_FFFF);
      send_entry(8'd0, 32'h0000_0000);
      send_entry(8'd255, 32'hFFFF_FFFF);
      send_map(0);
      send_map(254);
      send_map(255);

      // short palette over a symmetric range, fractional positions
      program_regs(-1000, 1000, fit_scale(-1000, 1000, 16), 9'd16);
      send_map(-1001);
      send_map(-1000);
      send_map(-999);
      send_map(-500);
      send_map(-1);
      send_map(0);
      send_map(1);
      send_map(500);
      send_map(999);
      send_map(1000);
      send_map(1001);

      // random traffic under a spread of register settings
      run_phase(0, 255, 24'd65536, 9'd256);
      run_phase(32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1, 9'd256);
      run_phase(-100, 100, fit_scale(-100, 100, 2), 9'd2);
      run_phase(0, 10, 24'hFF_FFFF, 9'd256);
      run_phase(500, 500, 24'd65536, 9'd8);
      run_phase(300, -300, 24'd4096, 9'd64);
      run_phase(-50, 50, 24'd65536, 9'd0);
      run_phase(-50, 50, 24'd65536, 9'd1);
      run_phase(0, 1000, fit_scale(0, 1000, 256), 9'd511);
      run_phase(-7, 9000, 24'd0, 9'd40);
      run_phase(-2000000, 3000000, fit_scale(-2000000, 3000000, 300), 9'd300);
      repeat (2) begin
         rlo  = $urandom;
         rhi  = rlo + 32'($urandom_range(1, 200000));
         rcnt = $urandom_range(2, 256);
         run_phase(rlo, rhi, fit_scale(rlo, rhi, rcnt), 9'(rcnt));
      end

      // drain and settle
      req_tvalid <= 1'b0;
      while (rgba_model.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d palette writes and %0d color lookups", rgba_model.writes,
               rgba_model.lookups);
      $display("across %0d register settings in %0d cycles", settings + 1, cycles);
      if (rgba_model.errors == 0 && rgba_model.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
